[rtl/mer_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer: register
// indexes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // default widths
  localparam int MER_COORD_WIDTH  = 12;
  localparam int MER_RADIUS_WIDTH = 10;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_Y = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRX,
    ST_SQRY,
    ST_RXRY,
    ST_INIT,
    ST_TX,
    ST_TXSQ,
    ST_TY,
    ST_TYSQ,
    ST_RXRY2,
    ST_ENTRY,
    ST_STEP,
    ST_OUT
  } state_t;

  // operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MUL_RX_RX,
    MUL_RY_RY,
    MUL_SQRX_RY,
    MUL_TX_TX,
    MUL_SQRY_PROD,
    MUL_TY_TY,
    MUL_SQRX_PROD,
    MUL_SQRX_SQRY
  } mul_sel_t;

  // datapath register updates
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SQRX,
    OP_SQRY,
    OP_INIT,
    OP_DEC_LOAD,
    OP_DEC_ADD4,
    OP_DEC_SUB4,
    OP_STEP
  } dp_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    dp_op_t   op;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic in_region_two;
    logic region_one_ok;
  } dp_status_t;

endpackage

[rtl/mer_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller state machine: sequences the multiplier for a restart and for
// the region change, issues single-cycle steps and hands results to the
// output register.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic                restart,
  input  logic                m_ready,
  output logic                m_valid,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    cmd
);
  import mer_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_valid || m_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          if (restart) begin
            state_next = ST_SQRX;
          end else if (status.finished) begin
            state_next = ST_OUT;
          end else if (status.region_one_ok || status.in_region_two) begin
            state_next = ST_STEP;
          end else begin
            state_next = ST_TX;
          end
        end
      end
      ST_SQRX:  state_next = ST_SQRY;
      ST_SQRY:  state_next = ST_RXRY;
      ST_RXRY:  state_next = ST_INIT;
      ST_INIT:  state_next = ST_OUT;
      ST_TX:    state_next = ST_TXSQ;
      ST_TXSQ:  state_next = ST_TY;
      ST_TY:    state_next = ST_TYSQ;
      ST_TYSQ:  state_next = ST_RXRY2;
      ST_RXRY2: state_next = ST_ENTRY;
      ST_ENTRY: state_next = ST_STEP;
      ST_STEP:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.mul_sel  = MUL_RX_RX;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    s_ready      = 1'b0;
    case (state)
      ST_IDLE:  s_ready = 1'b1;
      ST_SQRX:  cmd.mul_sel = MUL_RX_RX;
      ST_SQRY: begin
        cmd.mul_sel = MUL_RY_RY;
        cmd.op      = OP_SQRX;
      end
      ST_RXRY: begin
        cmd.mul_sel = MUL_SQRX_RY;
        cmd.op      = OP_SQRY;
      end
      ST_INIT:  cmd.op = OP_INIT;
      ST_TX:    cmd.mul_sel = MUL_TX_TX;
      ST_TXSQ:  cmd.mul_sel = MUL_SQRY_PROD;
      ST_TY: begin
        cmd.mul_sel = MUL_TY_TY;
        cmd.op      = OP_DEC_LOAD;
      end
      ST_TYSQ:  cmd.mul_sel = MUL_SQRX_PROD;
      ST_RXRY2: begin
        cmd.mul_sel = MUL_SQRX_SQRY;
        cmd.op      = OP_DEC_ADD4;
      end
      ST_ENTRY: cmd.op = OP_DEC_SUB4;
      ST_STEP:  cmd.op = OP_STEP;
      ST_OUT:   cmd.load_out = out_free;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.load_out) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

endmodule

[rtl/mer_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_dp
// Datapath: configuration registers, the shared multiplier with its product
// register, the offset/decision state with its step adders, and the
// output register.
// ----------------------------------------------------------------------------
module mer_dp #(
  parameter int COORD_WIDTH  = mer_pkg::MER_COORD_WIDTH,
  parameter int RADIUS_WIDTH = mer_pkg::MER_RADIUS_WIDTH,
  parameter int CFG_W        = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mer_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata,
  input  mer_pkg::dp_cmd_t              cmd,
  output mer_pkg::dp_status_t           status,
  output logic [COORD_WIDTH:0]          right_x,
  output logic [COORD_WIDTH:0]          left_x,
  output logic [COORD_WIDTH:0]          lower_y,
  output logic [COORD_WIDTH:0]          upper_y,
  output logic                          region,
  output logic                          last
);
  import mer_pkg::*;

  localparam int CW  = COORD_WIDTH - 1;     // center register width
  localparam int OW  = COORD_WIDTH + 1;     // output coordinate width
  localparam int R   = RADIUS_WIDTH;
  localparam int OFW = RADIUS_WIDTH + 1;    // offset width
  localparam int SQW = 2 * RADIUS_WIDTH;    // squared radius width
  localparam int TW  = 3 * RADIUS_WIDTH + 6; // step term width
  localparam int DW  = 4 * RADIUS_WIDTH;    // decision width
  localparam int MW  = 2 * RADIUS_WIDTH + 4; // multiplier operand width
  localparam int PW  = 2 * MW;

  logic [CW-1:0]         center_x, center_y;
  logic [R-1:0]          radius_x, radius_y;
  logic [SQW-1:0]        sq_rx, sq_ry;
  logic [OFW-1:0]        offset_x, offset_y;
  logic signed [TW-1:0]  step_term_x, step_term_y;
  logic signed [DW-1:0]  decision;
  logic                  in_region_two, finished;
  logic [PW-1:0]         prod;
  logic [MW-1:0]         mul_a, mul_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius_x <= '0;
      radius_y <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CENTER_X: center_x <= cfg_wdata[CW-1:0];
        CFG_CENTER_Y: center_y <= cfg_wdata[CW-1:0];
        CFG_RADIUS_X: radius_x <= cfg_wdata[R-1:0];
        CFG_RADIUS_Y: radius_y <= cfg_wdata[R-1:0];
        default:      center_x <= center_x;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = MW'(radius_x);
    mul_b = MW'(radius_x);
    case (cmd.mul_sel)
      MUL_RX_RX: begin
        mul_a = MW'(radius_x);
        mul_b = MW'(radius_x);
      end
      MUL_RY_RY: begin
        mul_a = MW'(radius_y);
        mul_b = MW'(radius_y);
      end
      MUL_SQRX_RY: begin
        mul_a = MW'(sq_rx);
        mul_b = MW'(radius_y);
      end
      MUL_TX_TX: begin
        mul_a = MW'({offset_x, 1'b1});
        mul_b = MW'({offset_x, 1'b1});
      end
      MUL_SQRY_PROD: begin
        mul_a = MW'(sq_ry);
        mul_b = prod[MW-1:0];
      end
      MUL_TY_TY: begin
        mul_a = MW'(offset_y - 1'b1);
        mul_b = MW'(offset_y - 1'b1);
      end
      MUL_SQRX_PROD: begin
        mul_a = MW'(sq_rx);
        mul_b = prod[MW-1:0];
      end
      MUL_SQRX_SQRY: begin
        mul_a = MW'(sq_rx);
        mul_b = MW'(sq_ry);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // widened operands for the step adders
  logic signed [TW-1:0] two_sqrx_t, two_sqry_t, stx_inc, sty_dec, rxry_t;
  logic signed [DW-1:0] sqrx_d, sqry_d, stx_inc_d, sty_dec_d, prod_d, rxry_d;
  logic signed [DW-1:0] r1_sum_a, r1_sum_b, r2_sum_a, r2_sum_b;
  logic signed [DW-1:0] init_dec;
  logic                 dec_pos, region_one_ok;

  assign two_sqrx_t = TW'({sq_rx, 1'b0});
  assign two_sqry_t = TW'({sq_ry, 1'b0});
  assign stx_inc    = step_term_x + two_sqry_t;
  assign sty_dec    = step_term_y - two_sqrx_t;
  assign rxry_t     = TW'(prod);

  assign sqrx_d    = DW'(sq_rx);
  assign sqry_d    = DW'(sq_ry);
  assign stx_inc_d = DW'(stx_inc);
  assign sty_dec_d = DW'(sty_dec);
  assign prod_d    = DW'(prod);
  assign rxry_d    = DW'(prod);

  assign r1_sum_a = stx_inc_d + sqry_d;
  assign r1_sum_b = stx_inc_d - sty_dec_d + sqry_d;
  assign r2_sum_a = sqrx_d - sty_dec_d;
  assign r2_sum_b = stx_inc_d - sty_dec_d + sqrx_d;
  assign init_dec = (sqry_d <<< 2) - (rxry_d <<< 2) + sqrx_d;

  assign dec_pos       = decision > 0;
  assign region_one_ok = !in_region_two && (step_term_x <= step_term_y);

  assign status.finished      = finished;
  assign status.in_region_two = in_region_two;
  assign status.region_one_ok = region_one_ok;

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_rx         <= '0;
      sq_ry         <= '0;
      offset_x      <= '0;
      offset_y      <= '0;
      step_term_x   <= '0;
      step_term_y   <= '0;
      decision      <= '0;
      in_region_two <= 1'b0;
      finished      <= 1'b1;
    end else begin
      case (cmd.op)
        OP_SQRX: sq_rx <= SQW'(prod);
        OP_SQRY: sq_ry <= SQW'(prod);
        OP_INIT: begin
          offset_x      <= '0;
          offset_y      <= OFW'(radius_y);
          step_term_x   <= '0;
          step_term_y   <= rxry_t <<< 1;
          decision      <= init_dec;
          in_region_two <= 1'b0;
          finished      <= (radius_y == '0);
        end
        OP_DEC_LOAD: decision <= prod_d;
        OP_DEC_ADD4: decision <= decision + (prod_d <<< 2);
        OP_DEC_SUB4: begin
          decision      <= decision - (prod_d <<< 2);
          in_region_two <= 1'b1;
        end
        OP_STEP: begin
          if (region_one_ok) begin
            // region one: x always advances
            offset_x    <= offset_x + 1'b1;
            step_term_x <= stx_inc;
            if (!dec_pos) begin
              decision <= decision + (r1_sum_a <<< 2);
              finished <= (offset_y == '0);
            end else begin
              offset_y    <= offset_y - 1'b1;
              step_term_y <= sty_dec;
              decision    <= decision + (r1_sum_b <<< 2);
              finished    <= (offset_y == OFW'(1));
            end
          end else begin
            // region two: y always falls
            offset_y    <= offset_y - 1'b1;
            step_term_y <= sty_dec;
            finished    <= (offset_y == OFW'(1));
            if (dec_pos) begin
              decision <= decision + (r2_sum_a <<< 2);
            end else begin
              offset_x    <= offset_x + 1'b1;
              step_term_x <= stx_inc;
              decision    <= decision + (r2_sum_b <<< 2);
            end
          end
        end
        default: decision <= decision;
      endcase
    end
  end

  // output register, mirrored about the center
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      right_x <= OW'(center_x) + OW'(offset_x);
      left_x  <= OW'(center_x) - OW'(offset_x);
      lower_y <= OW'(center_y) + OW'(offset_y);
      upper_y <= OW'(center_y) - OW'(offset_y);
      region  <= in_region_two;
      last    <= finished;
    end
  end

endmodule

[rtl/midpoint_ellipse_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Each input walks the controller states: a plain step STEP then OUT, a step
// after the walk has ended straight to OUT, a restart SQRX, SQRY, RXRY, INIT
// and OUT, the step entering region two TX, TXSQ, TY, TYSQ, RXRY2, ENTRY, STEP
// and OUT. Input tready is high only while the controller is idle, so a new
// input waits for the last result to load. Reset clears configuration and
// walk state; a step before any restart repeats the center point with last set.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_WIDTH  = mer_pkg::MER_COORD_WIDTH,
  parameter int RADIUS_WIDTH = mer_pkg::MER_RADIUS_WIDTH,
  localparam int CFG_W   = (COORD_WIDTH - 1 > RADIUS_WIDTH) ? COORD_WIDTH - 1 : RADIUS_WIDTH,
  localparam int TDATA_W = ((4 * (COORD_WIDTH + 1) + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [mer_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]               cfg_wdata,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // restart
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [TDATA_W-1:0]             m_axis_tdata,  // right_x, left_x, lower_y, upper_y
  output logic                           m_axis_tuser,  // region
  output logic                           m_axis_tlast
);
  import mer_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [COORD_WIDTH:0] right_x, left_x, lower_y, upper_y;

  // controller
  mer_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .restart (s_axis_tdata[0]),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath
  mer_dp #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH),
    .CFG_W        (CFG_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .right_x   (right_x),
    .left_x    (left_x),
    .lower_y   (lower_y),
    .upper_y   (upper_y),
    .region    (m_axis_tuser),
    .last      (m_axis_tlast)
  );

  // pack the four coordinates, first field lowest
  assign m_axis_tdata = TDATA_W'({upper_y, lower_y, left_x, right_x});

endmodule
